@@ sv/i2cstb_pkg.sv @@
package i2cstb_pkg;

  localparam int DefaultDepth = 256;
  localparam int CountW = 9;
  localparam int ByteW = 8;

  localparam logic [ByteW-1:0] FillByte = 8'hFF;
  localparam int RwBit = 0;

  // Item commands, carried in s_axis_tuser.
  localparam logic [1:0] CmdBusEvent = 2'd0;
  localparam logic [1:0] CmdLoadTx = 2'd1;
  localparam logic [1:0] CmdReadRx = 2'd2;
  localparam logic [1:0] CmdTakeCount = 2'd3;

  // Source of send_byte for a result.
  localparam logic [1:0] SendNone = 2'd0;
  localparam logic [1:0] SendMem = 2'd1;
  localparam logic [1:0] SendFill = 2'd2;

  localparam int InDataW = 32;
  localparam int OutDataW = 40;

  typedef struct packed {
    logic start;
    logic addr_hit;
    logic rx_ready;
    logic tx_ready;
    logic stop;
    logic nack;
  } bus_flags_t;

  // Result fields known at the accept edge; the byte fields follow from the
  // store read data registered at that edge.
  typedef struct packed {
    logic              send_valid;
    logic [1:0]        send_sel;
    logic              frame_done;
    logic [CountW-1:0] frame_count;
    logic [CountW-1:0] received_count;
    logic              read_ok;
    logic              addressed;
    logic              reading;
    logic              writing;
  } res_t;

endpackage

@@ sv/i2cstb_store.sv @@
module i2cstb_store #(
  parameter int Depth = i2cstb_pkg::DefaultDepth,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AddrW-1:0]             waddr_i,
  input  logic [i2cstb_pkg::ByteW-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [AddrW-1:0]             raddr_i,
  output logic [i2cstb_pkg::ByteW-1:0] rdata_o
);

  logic [i2cstb_pkg::ByteW-1:0] mem [Depth];
  logic [i2cstb_pkg::ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data only changes on a read, so it holds while the result waits.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/i2cstb_ctrl.sv @@
module i2cstb_ctrl #(
  parameter int Depth = i2cstb_pkg::DefaultDepth,
  parameter int AddrW = $clog2(Depth),
  parameter int PosW = $clog2(Depth + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [1:0]                    cmd_i,
  input  i2cstb_pkg::bus_flags_t        flags_i,
  input  logic [i2cstb_pkg::ByteW-1:0]  bus_byte_i,
  input  logic [i2cstb_pkg::ByteW-1:0]  entry_index_i,
  input  logic [i2cstb_pkg::ByteW-1:0]  entry_value_i,
  input  logic                          cfg_we_i,
  input  logic [i2cstb_pkg::CountW-1:0] cfg_data_i,
  output logic                          tx_we_o,
  output logic [AddrW-1:0]              tx_waddr_o,
  output logic [i2cstb_pkg::ByteW-1:0]  tx_wdata_o,
  output logic                          tx_re_o,
  output logic [AddrW-1:0]              tx_raddr_o,
  output logic                          rx_we_o,
  output logic [AddrW-1:0]              rx_waddr_o,
  output logic [i2cstb_pkg::ByteW-1:0]  rx_wdata_o,
  output logic                          rx_re_o,
  output logic [AddrW-1:0]              rx_raddr_o,
  output i2cstb_pkg::res_t              res_o
);

  localparam int CmpW = (PosW > i2cstb_pkg::CountW) ? PosW : i2cstb_pkg::CountW;

  logic [PosW-1:0]               rx_pos_q, rx_pos_d;
  logic [PosW-1:0]               tx_pos_q, tx_pos_d;
  logic [i2cstb_pkg::CountW-1:0] tx_len_q;
  logic                          matched_q, matched_d;
  logic                          rd_mode_q, rd_mode_d;
  logic                          wr_mode_q, wr_mode_d;
  logic [CmpW-1:0]               tx_limit;
  logic                          idx_ok;

  assign tx_limit = (CmpW'(tx_len_q) > CmpW'(Depth)) ? CmpW'(Depth) : CmpW'(tx_len_q);
  assign idx_ok = CmpW'(entry_index_i) < CmpW'(Depth);

  always_comb begin
    logic tx_rd;
    logic tx_fill;
    logic [AddrW-1:0] tx_addr;
    tx_rd = 1'b0;
    tx_fill = 1'b0;
    tx_addr = '0;
    rx_pos_d = rx_pos_q;
    tx_pos_d = tx_pos_q;
    matched_d = matched_q;
    rd_mode_d = rd_mode_q;
    wr_mode_d = wr_mode_q;
    tx_we_o = 1'b0;
    rx_we_o = 1'b0;
    rx_re_o = 1'b0;
    rx_waddr_o = '0;
    res_o = '0;

    case (cmd_i)
      i2cstb_pkg::CmdBusEvent: begin
        if (flags_i.start) begin
          matched_d = 1'b0;
          rd_mode_d = 1'b0;
          wr_mode_d = 1'b0;
        end
        if (flags_i.addr_hit) begin
          matched_d = 1'b1;
          if (bus_byte_i[i2cstb_pkg::RwBit]) begin
            rd_mode_d = 1'b1;
            tx_pos_d = '0;
            if (tx_limit != '0) begin
              tx_rd = 1'b1;
              tx_addr = '0;
              res_o.send_valid = 1'b1;
              tx_pos_d = PosW'(1);
            end
          end else begin
            wr_mode_d = 1'b1;
            rx_pos_d = '0;
          end
        end
        if (flags_i.rx_ready && wr_mode_d && (CmpW'(rx_pos_d) < CmpW'(Depth))) begin
          rx_we_o = 1'b1;
          rx_waddr_o = rx_pos_d[AddrW-1:0];
          rx_pos_d = rx_pos_d + PosW'(1);
        end
        // Only the last byte handed over in one item is reported, so a
        // single store read serves both the address read and a request.
        if (flags_i.tx_ready) begin
          res_o.send_valid = 1'b1;
          if (rd_mode_d && (CmpW'(tx_pos_d) < tx_limit)) begin
            tx_rd = 1'b1;
            tx_addr = tx_pos_d[AddrW-1:0];
            tx_pos_d = tx_pos_d + PosW'(1);
          end else begin
            tx_fill = 1'b1;
          end
        end
        if (flags_i.stop) begin
          if (wr_mode_d) begin
            res_o.frame_done = 1'b1;
            res_o.frame_count = i2cstb_pkg::CountW'(rx_pos_d);
          end
          matched_d = 1'b0;
          rd_mode_d = 1'b0;
          wr_mode_d = 1'b0;
          rx_pos_d = '0;
          tx_pos_d = '0;
        end
        if (flags_i.nack) begin
          rd_mode_d = 1'b0;
        end
        res_o.received_count = i2cstb_pkg::CountW'(rx_pos_d);
      end
      i2cstb_pkg::CmdLoadTx: begin
        tx_we_o = idx_ok;
        res_o.received_count = i2cstb_pkg::CountW'(rx_pos_q);
      end
      i2cstb_pkg::CmdReadRx: begin
        rx_re_o = idx_ok;
        res_o.read_ok = idx_ok;
        res_o.received_count = i2cstb_pkg::CountW'(rx_pos_q);
      end
      i2cstb_pkg::CmdTakeCount: begin
        res_o.received_count = i2cstb_pkg::CountW'(rx_pos_q);
        rx_pos_d = '0;
      end
      default: begin
        res_o.received_count = i2cstb_pkg::CountW'(rx_pos_q);
      end
    endcase

    if (tx_fill) begin
      res_o.send_sel = i2cstb_pkg::SendFill;
    end else if (tx_rd) begin
      res_o.send_sel = i2cstb_pkg::SendMem;
    end else begin
      res_o.send_sel = i2cstb_pkg::SendNone;
    end
    res_o.addressed = matched_d;
    res_o.reading = rd_mode_d;
    res_o.writing = wr_mode_d;

    tx_we_o = tx_we_o & accept_i;
    rx_we_o = rx_we_o & accept_i;
    rx_re_o = rx_re_o & accept_i;
    tx_re_o = tx_rd & ~tx_fill & accept_i;
    tx_raddr_o = tx_addr;
  end

  assign tx_waddr_o = AddrW'(entry_index_i);
  assign tx_wdata_o = entry_value_i;
  assign rx_wdata_o = bus_byte_i;
  assign rx_raddr_o = AddrW'(entry_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_pos_q <= '0;
      tx_pos_q <= '0;
      tx_len_q <= '0;
      matched_q <= 1'b0;
      rd_mode_q <= 1'b0;
      wr_mode_q <= 1'b0;
    end else begin
      if (accept_i) begin
        rx_pos_q <= rx_pos_d;
        tx_pos_q <= tx_pos_d;
        matched_q <= matched_d;
        rd_mode_q <= rd_mode_d;
        wr_mode_q <= wr_mode_d;
      end
      if (cfg_we_i) begin
        tx_len_q <= cfg_data_i;
        tx_pos_q <= '0;
      end
    end
  end

  a_mode_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_mode_q || wr_mode_q) |-> matched_q)
    else $error("transfer mode set without address match");

  a_tx_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(tx_pos_q) <= tx_limit)
    else $error("transmit position beyond transmit limit");

  a_rx_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(rx_pos_q) <= CmpW'(Depth))
    else $error("receive position beyond buffer depth");

endmodule

@@ sv/i2c_slave_transfer_buffer_unit.sv @@
// Slave-side I2C transfer buffer for one bus channel.
// s_axis carries one item per bus event or software access: tuser holds the
// command (bus event, load transmit entry, read receive entry, take and clear
// count), tdata holds the bus flags, the bus byte, the entry index and the
// entry value. Every accepted item yields exactly one item on m_axis with the
// send byte, the finished-frame report, the receive count, the read-back byte
// and the addressed/read/write status.
// The cfg channel writes the transmit length; a write also rewinds the
// transmit position. It is meant to be used only while no item is in flight.
// An accepted item passes the pending register, then the output register that
// drives m_axis_tvalid: the store is read synchronously at the accept edge,
// then the result is formed; s_axis_tready stays low while an item is pending.
// If the receiver stalls, one finished item sits in the output register and
// one more item is accepted and held until the output register frees up.
// Reset clears positions, modes, the transmit length and both handshakes; the
// store contents are not cleared and read back as whatever was written last.
module i2c_slave_transfer_buffer_unit #(
  parameter int BufferDepth = i2cstb_pkg::DefaultDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] start_seen, [1] address_hit, [2] receive_ready, [3] transmit_ready,
  // [4] stop_seen, [5] nack_seen, [13:6] bus_byte, [21:14] entry_index,
  // [29:22] entry_value, [31:30] zero
  input  logic [i2cstb_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] command
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] send_valid, [8:1] send_byte, [9] frame_done, [18:10] frame_count,
  // [27:19] received_count, [35:28] read_byte, [36] addressed,
  // [37] master_reading, [38] master_writing, [39] zero
  output logic [i2cstb_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [i2cstb_pkg::CountW-1:0]    cfg_data_i
);

  localparam int AddrW = $clog2(BufferDepth);
  localparam int PosW = $clog2(BufferDepth + 1);

  logic                         accept;
  i2cstb_pkg::bus_flags_t       flags;
  i2cstb_pkg::res_t             res;
  i2cstb_pkg::res_t             pend_res_q;
  logic                         pend_q;
  logic                         out_valid_q;
  logic [i2cstb_pkg::OutDataW-1:0] out_data_q;
  logic                         out_load;

  logic                         tx_we, tx_re, rx_we, rx_re;
  logic [AddrW-1:0]             tx_waddr, tx_raddr, rx_waddr, rx_raddr;
  logic [i2cstb_pkg::ByteW-1:0] tx_wdata, rx_wdata, tx_rdata, rx_rdata;
  logic [i2cstb_pkg::ByteW-1:0] send_byte, read_byte;

  assign s_axis_tready = ~pend_q;
  assign accept = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o = 1'b1;

  assign flags.start = s_axis_tdata[0];
  assign flags.addr_hit = s_axis_tdata[1];
  assign flags.rx_ready = s_axis_tdata[2];
  assign flags.tx_ready = s_axis_tdata[3];
  assign flags.stop = s_axis_tdata[4];
  assign flags.nack = s_axis_tdata[5];

  i2cstb_ctrl #(
    .Depth(BufferDepth),
    .AddrW(AddrW),
    .PosW (PosW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cmd_i        (s_axis_tuser),
    .flags_i      (flags),
    .bus_byte_i   (s_axis_tdata[13:6]),
    .entry_index_i(s_axis_tdata[21:14]),
    .entry_value_i(s_axis_tdata[29:22]),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .tx_we_o      (tx_we),
    .tx_waddr_o   (tx_waddr),
    .tx_wdata_o   (tx_wdata),
    .tx_re_o      (tx_re),
    .tx_raddr_o   (tx_raddr),
    .rx_we_o      (rx_we),
    .rx_waddr_o   (rx_waddr),
    .rx_wdata_o   (rx_wdata),
    .rx_re_o      (rx_re),
    .rx_raddr_o   (rx_raddr),
    .res_o        (res)
  );

  i2cstb_store #(
    .Depth(BufferDepth),
    .AddrW(AddrW)
  ) u_tx_store (
    .clk_i  (clk_i),
    .we_i   (tx_we),
    .waddr_i(tx_waddr),
    .wdata_i(tx_wdata),
    .re_i   (tx_re),
    .raddr_i(tx_raddr),
    .rdata_o(tx_rdata)
  );

  i2cstb_store #(
    .Depth(BufferDepth),
    .AddrW(AddrW)
  ) u_rx_store (
    .clk_i  (clk_i),
    .we_i   (rx_we),
    .waddr_i(rx_waddr),
    .wdata_i(rx_wdata),
    .re_i   (rx_re),
    .raddr_i(rx_raddr),
    .rdata_o(rx_rdata)
  );

  always_comb begin
    case (pend_res_q.send_sel)
      i2cstb_pkg::SendMem:  send_byte = tx_rdata;
      i2cstb_pkg::SendFill: send_byte = i2cstb_pkg::FillByte;
      default:              send_byte = '0;
    endcase
  end

  assign read_byte = pend_res_q.read_ok ? rx_rdata : '0;
  assign out_load = pend_q & (~out_valid_q | m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pend_q <= 1'b1;
      end else if (out_load) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_res_q <= res;
    end
    if (out_load) begin
      out_data_q <= {1'b0,
                     pend_res_q.writing,
                     pend_res_q.reading,
                     pend_res_q.addressed,
                     read_byte,
                     pend_res_q.received_count,
                     pend_res_q.frame_count,
                     pend_res_q.frame_done,
                     send_byte,
                     pend_res_q.send_valid};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;

  a_no_accept_while_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !accept)
    else $error("item accepted while another is still pending");

  a_accept_then_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pend_q)
    else $error("accepted item did not reach the pending stage");

  a_done_ends_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[9]) |-> (out_data_q[38:36] == 3'b000))
    else $error("frame done reported with transfer still open");

endmodule

@@ verif/transfer_buffer_checker.sv @@
`timescale 1ns / 1ps

// Watches the item, result and register channels of the transfer buffer,
// keeps its own copy of the buffer state and compares every result item,
// in order, with the one worked out from the accepted input item.
module transfer_buffer_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [i2cstb_pkg::InDataW-1:0]      in_data_i,
  input  logic [1:0]                          in_cmd_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [i2cstb_pkg::OutDataW-1:0]     out_data_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [i2cstb_pkg::CountW-1:0]       cfg_data_i,
  output int                                  mismatches_o,
  output int                                  replies_awaited_o,
  output logic [i2cstb_pkg::CountW-1:0]       rx_filled_o,
  output logic [i2cstb_pkg::CountW-1:0]       tx_pos_o
);

  localparam int Depth = i2cstb_pkg::DefaultDepth;

  typedef struct packed {
    logic                          send_valid;
    logic [i2cstb_pkg::ByteW-1:0]  send_byte;
    logic                          frame_done;
    logic [i2cstb_pkg::CountW-1:0] frame_count;
    logic [i2cstb_pkg::CountW-1:0] received_count;
    logic [i2cstb_pkg::ByteW-1:0]  read_byte;
    logic                          addressed;
    logic                          reading;
    logic                          writing;
  } reply_t;

  logic [i2cstb_pkg::ByteW-1:0]  rx_mem [Depth];
  logic [i2cstb_pkg::ByteW-1:0]  tx_mem [Depth];
  logic [i2cstb_pkg::CountW-1:0] rx_pos = '0;
  logic [i2cstb_pkg::CountW-1:0] tx_pos = '0;
  logic [i2cstb_pkg::CountW-1:0] tx_len = '0;
  logic                          matched = 1'b0;
  logic                          rd_mode = 1'b0;
  logic                          wr_mode = 1'b0;
  logic [i2cstb_pkg::CountW-1:0] rx_high = '0;

  reply_t awaited_replies [$];
  reply_t got;
  reply_t want;

  assign rx_filled_o = rx_high;
  assign tx_pos_o = tx_pos;

  function automatic logic [i2cstb_pkg::CountW-1:0] tx_limit();
    return (tx_len > Depth) ? i2cstb_pkg::CountW'(Depth) : tx_len;
  endfunction

  // Applies one item to the buffer copy and returns the result it causes.
  function automatic reply_t compute_reply(input logic [1:0] cmd,
                                           input logic [i2cstb_pkg::InDataW-1:0] d);
    reply_t                       r;
    logic [i2cstb_pkg::ByteW-1:0] bus;
    logic [i2cstb_pkg::ByteW-1:0] idx;
    logic [i2cstb_pkg::ByteW-1:0] val;
    r = '0;
    bus = d[13:6];
    idx = d[21:14];
    val = d[29:22];
    case (cmd)
      i2cstb_pkg::CmdBusEvent: begin
        if (d[0]) begin
          matched = 1'b0;
          rd_mode = 1'b0;
          wr_mode = 1'b0;
        end
        if (d[1]) begin
          matched = 1'b1;
          if (bus[i2cstb_pkg::RwBit]) begin
            rd_mode = 1'b1;
            tx_pos = '0;
            if (tx_pos < tx_limit()) begin
              r.send_byte = tx_mem[tx_pos[i2cstb_pkg::ByteW-1:0]];
              r.send_valid = 1'b1;
              tx_pos++;
            end
          end else begin
            wr_mode = 1'b1;
            rx_pos = '0;
          end
        end
        // The address byte doubles as data when both flags are set.
        if (d[2] && wr_mode && rx_pos < Depth) begin
          rx_mem[rx_pos[i2cstb_pkg::ByteW-1:0]] = bus;
          rx_pos++;
          if (rx_pos > rx_high) rx_high = rx_pos;
        end
        if (d[3]) begin
          r.send_valid = 1'b1;
          if (rd_mode && tx_pos < tx_limit()) begin
            r.send_byte = tx_mem[tx_pos[i2cstb_pkg::ByteW-1:0]];
            tx_pos++;
          end else begin
            r.send_byte = i2cstb_pkg::FillByte;
          end
        end
        if (d[4]) begin
          if (wr_mode) begin
            r.frame_done = 1'b1;
            r.frame_count = rx_pos;
          end
          matched = 1'b0;
          rd_mode = 1'b0;
          wr_mode = 1'b0;
          rx_pos = '0;
          tx_pos = '0;
        end
        if (d[5]) rd_mode = 1'b0;
        r.received_count = rx_pos;
      end
      // An 8-bit index always falls inside the default depth.
      i2cstb_pkg::CmdLoadTx: begin
        tx_mem[idx] = val;
        r.received_count = rx_pos;
      end
      i2cstb_pkg::CmdReadRx: begin
        r.read_byte = rx_mem[idx];
        r.received_count = rx_pos;
      end
      default: begin
        r.received_count = rx_pos;
        rx_pos = '0;
      end
    endcase
    r.addressed = matched;
    r.reading = rd_mode;
    r.writing = wr_mode;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rx_pos = '0;
      tx_pos = '0;
      tx_len = '0;
      matched = 1'b0;
      rd_mode = 1'b0;
      wr_mode = 1'b0;
      rx_high = '0;
      awaited_replies.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.send_valid = out_data_i[0];
        got.send_byte = out_data_i[8:1];
        got.frame_done = out_data_i[9];
        got.frame_count = out_data_i[18:10];
        got.received_count = out_data_i[27:19];
        got.read_byte = out_data_i[35:28];
        got.addressed = out_data_i[36];
        got.reading = out_data_i[37];
        got.writing = out_data_i[38];
        if (awaited_replies.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t: result item with none awaited: %h", $realtime, out_data_i);
        end else begin
          want = awaited_replies.pop_front();
          if (got !== want) begin
            mismatches_o++;
            if (mismatches_o <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected sv=%0d sb=%h fd=%0d fc=%0d rc=%0d rb=%h a=%0d r=%0d w=%0d",
                       want.send_valid, want.send_byte, want.frame_done,
                       want.frame_count, want.received_count, want.read_byte,
                       want.addressed, want.reading, want.writing);
              $display("  actual   sv=%0d sb=%h fd=%0d fc=%0d rc=%0d rb=%h a=%0d r=%0d w=%0d",
                       got.send_valid, got.send_byte, got.frame_done,
                       got.frame_count, got.received_count, got.read_byte,
                       got.addressed, got.reading, got.writing);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        tx_len = cfg_data_i;
        tx_pos = '0;
      end
      if (in_valid_i && in_ready_i)
        awaited_replies.push_back(compute_reply(in_cmd_i, in_data_i));
    end
    replies_awaited_o = awaited_replies.size();
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam logic [5:0] FlagStart = 6'h01;
  localparam logic [5:0] FlagAddr  = 6'h02;
  localparam logic [5:0] FlagRx    = 6'h04;
  localparam logic [5:0] FlagTx    = 6'h08;
  localparam logic [5:0] FlagStop  = 6'h10;
  localparam logic [5:0] FlagNack  = 6'h20;

  localparam int ReadyFree   = 0;
  localparam int ReadyChoppy = 1;
  localparam int ReadySlow   = 2;

  localparam int IdleLimit = 4000;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [i2cstb_pkg::InDataW-1:0]      s_axis_tdata = '0;
  logic [1:0]                          s_axis_tuser = i2cstb_pkg::CmdBusEvent;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [i2cstb_pkg::OutDataW-1:0]     m_axis_tdata;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [i2cstb_pkg::CountW-1:0]       cfg_data_i = '0;

  int                                  mismatches;
  int                                  replies_awaited;
  logic [i2cstb_pkg::CountW-1:0]       rx_filled;
  logic [i2cstb_pkg::CountW-1:0]       tx_next;

  int burst_left = 0;
  int sent = 0;
  int tx_lim_now = 0;
  bit tx_loaded [i2cstb_pkg::DefaultDepth];
  int ready_mode = ReadyFree;
  int ready_left = 0;
  int idle_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  i2c_slave_transfer_buffer_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  transfer_buffer_checker reply_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_i       (s_axis_tready),
    .in_data_i        (s_axis_tdata),
    .in_cmd_i         (s_axis_tuser),
    .out_valid_i      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_data_i       (m_axis_tdata),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .mismatches_o     (mismatches),
    .replies_awaited_o(replies_awaited),
    .rx_filled_o      (rx_filled),
    .tx_pos_o         (tx_next)
  );

  // The receiver switches between free-running, choppy and slow stretches.
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(ReadyFree, ReadySlow);
      ready_left = $urandom_range(16, 80);
    end
    ready_left--;
    case (ready_mode)
      ReadyFree:   m_axis_tready <= 1'b1;
      ReadyChoppy: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default:     m_axis_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL i2c_slave_transfer_buffer_unit");
        $finish;
      end
    end
  end

  // Every call returns at a falling edge with the accepted item possibly still
  // on the bus; the next call or the caller replaces or lowers it there.
  task automatic send_item(input logic [1:0] cmd, input logic [5:0] flags,
                           input logic [7:0] bus, input logic [7:0] idx,
                           input logic [7:0] val);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {2'b00, val, idx, bus, flags};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    sent++;
  endtask

  // Transmit entries that a bus event may fetch are loaded just before it,
  // so a reading master never fetches an entry that was never written.
  task automatic bus_event(input logic [5:0] flags, input logic [7:0] bus);
    int need [3];
    need[0] = 0;
    need[1] = 1;
    need[2] = int'(tx_next);
    foreach (need[k])
      if (need[k] < tx_lim_now && !tx_loaded[need[k]])
        load_tx(8'(need[k]), 8'($urandom));
    send_item(i2cstb_pkg::CmdBusEvent, flags, bus, 8'($urandom), 8'($urandom));
  endtask

  task automatic load_tx(input logic [7:0] idx, input logic [7:0] val);
    send_item(i2cstb_pkg::CmdLoadTx, 6'($urandom), 8'($urandom), idx, val);
    tx_loaded[idx] = 1'b1;
  endtask

  task automatic read_rx_at(input logic [7:0] idx);
    send_item(i2cstb_pkg::CmdReadRx, 6'($urandom), 8'($urandom), idx, 8'($urandom));
  endtask

  // Only entries that a master has already written are read back.
  task automatic read_rx_any();
    if (rx_filled != 0) read_rx_at(8'($urandom_range(0, rx_filled - 1)));
  endtask

  task automatic take_count();
    send_item(i2cstb_pkg::CmdTakeCount, 6'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  task automatic set_length(input int len);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (replies_awaited != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= i2cstb_pkg::CountW'(len);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    tx_lim_now = (len > i2cstb_pkg::DefaultDepth) ? i2cstb_pkg::DefaultDepth : len;
  endtask

  task automatic write_frame(input int n, input bit extras);
    logic [5:0] lead;
    lead = ($urandom_range(0, 3) != 0) ? (FlagStart | FlagAddr) : FlagAddr;
    bus_event(lead, {7'($urandom), 1'b0});
    for (int i = 0; i < n; i++) begin
      if (extras && $urandom_range(0, 9) == 0) take_count();
      if (extras && $urandom_range(0, 11) == 0) read_rx_any();
      bus_event(FlagRx | ((extras && $urandom_range(0, 15) == 0) ? FlagNack : 6'h00),
                8'($urandom));
    end
    bus_event(FlagStop | ($urandom_range(0, 1) ? FlagRx : 6'h00), 8'($urandom));
  endtask

  task automatic read_frame(input int n);
    bus_event(FlagStart | FlagAddr, {7'($urandom), 1'b1});
    for (int i = 0; i < n; i++)
      bus_event(FlagTx | ((i == n - 1 && $urandom_range(0, 1)) ? FlagNack : 6'h00),
                8'($urandom));
    bus_event(FlagStop, 8'($urandom));
  endtask

  task automatic transaction();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: write_frame($urandom_range(0, 7), 1'b1);
      4, 5, 6: read_frame($urandom_range(0, ((tx_lim_now < 6) ? tx_lim_now : 6) + 2));
      7: begin
        case ($urandom_range(0, 2))
          0: load_tx(8'($urandom), 8'($urandom));
          1: read_rx_any();
          default: take_count();
        endcase
      end
      8: bus_event(6'($urandom), 8'($urandom));
      default: begin
        // A transfer broken off by a repeated start or an early stop.
        bus_event(FlagStart | FlagAddr, 8'($urandom));
        if ($urandom_range(0, 1))
          bus_event(FlagStart | FlagAddr | ($urandom_range(0, 1) ? FlagRx : 6'h00),
                    8'($urandom));
        else
          bus_event(FlagStop, 8'($urandom));
      end
    endcase
  endtask

  task automatic run_phase(input int len, input int count, input bit long_frames);
    int first;
    set_length(len);
    first = sent;
    if (long_frames) begin
      // Overfill the receive buffer, then read back its last entry.
      write_frame(258, 1'b0);
      read_rx_at(8'hFF);
    end
    while (sent - first < count) transaction();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    load_tx(8'h00, 8'h00);
    load_tx(8'h01, 8'hFF);
    load_tx(8'h02, 8'h5A);
    set_length(3);

    take_count();
    bus_event(FlagStart | FlagAddr, 8'hFE);
    bus_event(FlagRx, 8'hFF);
    bus_event(FlagRx, 8'h00);
    take_count();
    bus_event(FlagRx, 8'hA5);
    read_rx_at(8'h00);
    read_rx_at(8'h01);
    bus_event(FlagStop, 8'h00);
    // Address and data in one item, then a stop that also carries data.
    bus_event(FlagAddr | FlagRx, 8'h40);
    bus_event(FlagStop | FlagRx, 8'h11);
    bus_event(FlagStart | FlagAddr, 8'h01);
    bus_event(FlagTx, 8'h00);
    bus_event(FlagTx, 8'h00);
    bus_event(FlagTx, 8'h00);
    bus_event(FlagTx | FlagNack, 8'h00);
    bus_event(FlagTx, 8'h00);
    bus_event(FlagRx, 8'h77);
    bus_event(FlagStop, 8'h00);
    bus_event(FlagStop, 8'h00);
    bus_event(6'h3F, 8'hFF);
    load_tx(8'hFF, 8'hFF);
    load_tx(8'h00, 8'h00);
    read_rx_at(8'h01);

    run_phase(0, 14, 1'b0);
    run_phase(1, 14, 1'b0);
    run_phase(17, 14, 1'b0);
    run_phase(256, 14, 1'b1);
    run_phase(511, 14, 1'b0);
    run_phase(100, 14, 1'b0);
    run_phase(2, 14, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (replies_awaited != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && replies_awaited == 0)
      $display("PASS i2c_slave_transfer_buffer_unit");
    else
      $display("FAIL i2c_slave_transfer_buffer_unit");
    $finish;
  end

endmodule
